[rtl/core/assert_macros.svh]
// assertion macros used by the tracker unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion lbl failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion lbl failed");

`endif

[rtl/core/mlpt_pkg.sv]
// types and constants of the mic level and presence tracker
`timescale 1ns / 1ps

package mlpt_pkg;

   localparam int FS_BITS    = 12;
   localparam int WIN_BITS   = 16;
   localparam int NEAR_BITS  = 15;
   localparam int DIST_BITS  = 16;
   localparam int TIME_BITS  = 32;
   localparam int LEVEL_BITS = 16;
   localparam int DIV_STEPS  = 15;
   localparam int CNT_BITS   = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE     = 16'h8000;
   localparam logic [WIN_BITS-1:0]   WINDOW_MS_RST = 16'd1000;
   localparam logic [FS_BITS-1:0]    FULL_SCALE_RST = 12'd1024;
   localparam logic [NEAR_BITS-1:0]  NEAR_MM_RST   = 15'd1000;
   localparam logic [DIST_BITS-1:0]  DIST_NONE     = 16'hFFFF;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_WINDOW_MS    = 2'd0,
      REG_FULL_SCALE   = 2'd1,
      REG_NEAR_MM      = 2'd2,
      REG_RANGE_FITTED = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_SEND = 3'b100
   } state_type;

endpackage

[rtl/core/mic_level_presence_tracker_unit.sv]
// top level of the mic level and presence tracker
//
//  channel   | handshake            | direction | payload
//  ----------+----------------------+-----------+------------------------------------------
//  req       | req_valid/req_ready  | in        | now_ms, mic_sample, range_ready, range_mm
//  rsp       | rsp_valid/rsp_ready  | out       | noise_level, window_closed, is_present,
//            |                      |           | held_distance_mm, absent_ms
//  csr       | psel/penable/pready  | in/out    | 4 registers at byte address 4*i
//
// a transaction is taken in the idle state; the send state then loads the output register
// a window close with a nonzero span below full scale also passes the divide state:
//   the bit-serial restoring divider produces one quotient bit per cycle for a 15-bit quotient
// reset is synchronous, active high; state and config registers go to documented defaults
// the output register lets the next transaction in while a result still waits on rsp_ready
// a finished result waits in the send state while the output register is occupied
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mic_level_presence_tracker_unit #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input transactions
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mlpt_pkg::TIME_BITS-1:0]        req_now_ms,
   input  logic [SAMPLE_BITS-1:0]                req_mic_sample,
   input  logic                                  req_range_ready,
   input  logic signed [mlpt_pkg::DIST_BITS-1:0] req_range_mm,
   // result transactions
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mlpt_pkg::LEVEL_BITS-1:0]       rsp_noise_level,
   output logic                                  rsp_window_closed,
   output logic                                  rsp_is_present,
   output logic signed [mlpt_pkg::DIST_BITS-1:0] rsp_held_distance_mm,
   output logic [mlpt_pkg::TIME_BITS-1:0]        rsp_absent_ms,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mlpt_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [mlpt_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [mlpt_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);
   import mlpt_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   // width wide enough to compare span against full scale
   localparam int CMP_BITS = (SAMPLE_BITS > FS_BITS) ? SAMPLE_BITS : FS_BITS;

   // configuration registers
   logic [WIN_BITS-1:0]  window_ms_ff;
   logic [FS_BITS-1:0]   full_scale_ff;
   logic [NEAR_BITS-1:0] near_mm_ff;
   logic                 range_fitted_ff;

   // tracker state
   state_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0] window_low_ff, window_low_in;
   logic [SAMPLE_BITS-1:0] window_high_ff, window_high_in;
   logic [TIME_BITS-1:0]   window_start_ff, window_start_in;
   logic [LEVEL_BITS-1:0]  level_hold_ff, level_hold_in;
   logic [DIST_BITS-1:0]   distance_hold_ff, distance_hold_in;
   logic                   was_present_ff, was_present_in;
   logic [TIME_BITS-1:0]   absent_since_ff, absent_since_in;

   // divider
   logic [FS_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_STEPS-1:0]   quot_ff, quot_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;

   // result waiting for the output register
   logic                   res_closed_ff, res_closed_in;
   logic                   res_present_ff, res_present_in;
   logic [TIME_BITS-1:0]   res_absent_ff, res_absent_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]  rsp_level_ff;
   logic                   rsp_closed_ff;
   logic                   rsp_present_ff;
   logic [DIST_BITS-1:0]   rsp_dist_ff;
   logic [TIME_BITS-1:0]   rsp_absent_ff;

   logic                   accept;
   logic                   load_out;
   logic                   csr_write;
   reg_index_type          csr_index;

   logic [SAMPLE_BITS-1:0] lo_new, hi_new, span;
   logic [TIME_BITS-1:0]   elapsed;
   logic                   close;
   logic                   span_ge_fs;
   logic                   dist_take;
   logic [DIST_BITS-1:0]   dist_new;
   logic                   present;
   logic [FS_BITS:0]       trial;
   logic [FS_BITS:0]       fs_wide;
   logic                   trial_ge;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign load_out = (state_ff == S_SEND) && (!rsp_valid_ff || rsp_ready);

   // window: take the sample in first, then see if the window has run out
   assign lo_new     = (req_mic_sample < window_low_ff)  ? req_mic_sample : window_low_ff;
   assign hi_new     = (req_mic_sample > window_high_ff) ? req_mic_sample : window_high_ff;
   assign span       = (hi_new >= lo_new) ? (hi_new - lo_new) : '0;
   assign elapsed    = req_now_ms - window_start_ff;
   assign close      = elapsed >= {{(TIME_BITS-WIN_BITS){1'b0}}, window_ms_ff};
   assign span_ge_fs = CMP_BITS'(span) >= CMP_BITS'(full_scale_ff);

   // presence: only positive readings are latched
   assign dist_take = range_fitted_ff && req_range_ready && !req_range_mm[DIST_BITS-1]
                      && (req_range_mm != '0);
   assign dist_new  = dist_take ? req_range_mm : distance_hold_ff;
   assign present   = !range_fitted_ff
                      || (!dist_new[DIST_BITS-1] && (dist_new != '0)
                          && (dist_new[NEAR_BITS-1:0] < near_mm_ff));

   // one restoring step: the dividend bits below the span are all zero
   assign trial    = {rem_ff, 1'b0};
   assign fs_wide  = {1'b0, full_scale_ff};
   assign trial_ge = trial >= fs_wide;

   always_comb begin
      state_in         = state_ff;
      window_low_in    = window_low_ff;
      window_high_in   = window_high_ff;
      window_start_in  = window_start_ff;
      level_hold_in    = level_hold_ff;
      distance_hold_in = distance_hold_ff;
      was_present_in   = was_present_ff;
      absent_since_in  = absent_since_ff;
      rem_in           = rem_ff;
      quot_in          = quot_ff;
      cnt_in           = cnt_ff;
      res_closed_in    = res_closed_ff;
      res_present_in   = res_present_ff;
      res_absent_in    = res_absent_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in         = S_SEND;
               distance_hold_in = dist_new;
               was_present_in   = present;
               res_closed_in    = close;
               res_present_in   = present;
               res_absent_in    = '0;
               if (!present && was_present_ff) begin
                  absent_since_in = req_now_ms;
               end else if (!present) begin
                  res_absent_in = req_now_ms - absent_since_ff;
               end
               if (close) begin
                  window_low_in   = SAMPLE_MAX;
                  window_high_in  = '0;
                  window_start_in = req_now_ms;
                  if (span == '0) begin
                     level_hold_in = '0;
                  end else if (span_ge_fs) begin
                     // also covers a zero full scale
                     level_hold_in = LEVEL_ONE;
                  end else begin
                     rem_in   = FS_BITS'(span);
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end else begin
                  window_low_in  = lo_new;
                  window_high_in = hi_new;
               end
            end
         end
         S_DIV: begin
            rem_in  = trial_ge ? FS_BITS'(trial - fs_wide) : trial[FS_BITS-1:0];
            quot_in = {quot_ff[DIV_STEPS-2:0], trial_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               level_hold_in = {1'b0, quot_ff[DIV_STEPS-2:0], trial_ge};
               state_in      = S_SEND;
            end
         end
         S_SEND: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      unique case (csr_index)
         REG_WINDOW_MS:    prdata = CSR_DATA_BITS'(window_ms_ff);
         REG_FULL_SCALE:   prdata = CSR_DATA_BITS'(full_scale_ff);
         REG_NEAR_MM:      prdata = CSR_DATA_BITS'(near_mm_ff);
         REG_RANGE_FITTED: prdata = CSR_DATA_BITS'(range_fitted_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff    <= WINDOW_MS_RST;
         full_scale_ff   <= FULL_SCALE_RST;
         near_mm_ff      <= NEAR_MM_RST;
         range_fitted_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_MS:    window_ms_ff    <= pwdata[WIN_BITS-1:0];
            REG_FULL_SCALE:   full_scale_ff   <= pwdata[FS_BITS-1:0];
            REG_NEAR_MM:      near_mm_ff      <= pwdata[NEAR_BITS-1:0];
            REG_RANGE_FITTED: range_fitted_ff <= pwdata[0];
            default:          range_fitted_ff <= range_fitted_ff;
         endcase
      end
   end

   // control and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         window_low_ff    <= SAMPLE_MAX;
         window_high_ff   <= '0;
         window_start_ff  <= '0;
         level_hold_ff    <= '0;
         distance_hold_ff <= DIST_NONE;
         was_present_ff   <= 1'b1;
         absent_since_ff  <= '0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         window_low_ff    <= window_low_in;
         window_high_ff   <= window_high_in;
         window_start_ff  <= window_start_in;
         level_hold_ff    <= level_hold_in;
         distance_hold_ff <= distance_hold_in;
         was_present_ff   <= was_present_in;
         absent_since_ff  <= absent_since_in;
         cnt_ff           <= cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      res_closed_ff  <= res_closed_in;
      res_present_ff <= res_present_in;
      res_absent_ff  <= res_absent_in;
      if (load_out) begin
         rsp_level_ff   <= level_hold_ff;
         rsp_closed_ff  <= res_closed_ff;
         rsp_present_ff <= res_present_ff;
         rsp_dist_ff    <= distance_hold_ff;
         rsp_absent_ff  <= res_absent_ff;
      end
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_noise_level      = rsp_level_ff;
   assign rsp_window_closed    = rsp_closed_ff;
   assign rsp_is_present       = rsp_present_ff;
   assign rsp_held_distance_mm = rsp_dist_ff;
   assign rsp_absent_ms        = rsp_absent_ff;

   // divider remainder stays below full scale
   `ASSERT_IMPL(a_rem_below_fs, clock, reset, state_ff == S_DIV, rem_ff < full_scale_ff)
   // divide runs into send or keeps going
   `ASSERT_NEXT(a_div_exit, clock, reset, state_ff == S_DIV,
                state_ff == S_DIV || state_ff == S_SEND)
   // level saturates at one
   `ASSERT_IMPL(a_level_sat, clock, reset, rsp_valid_ff, rsp_level_ff <= LEVEL_ONE)
   // no absent time while present
   `ASSERT_IMPL(a_present_absent, clock, reset, rsp_valid_ff && rsp_present_ff,
                rsp_absent_ff == '0)

endmodule

[tb/mic_level_presence_tracker_unit_tb.sv]
// self-checking testbench for the mic level and presence tracker, directed and random ticks against a predictor
`timescale 1ns / 1ps

module mic_level_presence_tracker_unit_tb;
   import mlpt_pkg::*;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 153;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 40;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int MAX_PRINTS      = 100;

   // ------------------------------------------------------------------
   // scoreboard: own copy of the tracker state, one expected result per tick
   // ------------------------------------------------------------------
   class level_presence_scoreboard;
      typedef struct packed {
         logic [LEVEL_BITS-1:0] noise_level;
         logic                  window_closed;
         logic                  is_present;
         logic [DIST_BITS-1:0]  held_distance_mm;
         logic [TIME_BITS-1:0]  absent_ms;
      } tick_result_type;

      // register copies
      logic [WIN_BITS-1:0]  win_len;
      logic [FS_BITS-1:0]   fs;
      logic [NEAR_BITS-1:0] near;
      logic                 fitted;

      // tracker state
      logic [11:0]                 win_lo;
      logic [11:0]                 win_hi;
      logic [TIME_BITS-1:0]        win_start;
      logic [LEVEL_BITS-1:0]       level;
      logic signed [DIST_BITS-1:0] held_dist;
      logic                        was_pres;
      logic [TIME_BITS-1:0]        absent_from;

      tick_result_type pending[$];
      int errors;

      function new();
         errors = 0;
         win_len = WINDOW_MS_RST;
         fs = FULL_SCALE_RST;
         near = NEAR_MM_RST;
         fitted = 1'b1;
         win_lo = 12'hFFF;
         win_hi = '0;
         win_start = '0;
         level = '0;
         held_dist = DIST_NONE;
         was_pres = 1'b1;
         absent_from = '0;
      endfunction

      function void set_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_WINDOW_MS:    win_len = value[WIN_BITS-1:0];
            REG_FULL_SCALE:   fs = value[FS_BITS-1:0];
            REG_NEAR_MM:      near = value[NEAR_BITS-1:0];
            REG_RANGE_FITTED: fitted = value[0];
            default: ;
         endcase
      endfunction

      // span over full scale in unsigned q1.15, truncated then clamped to 1.0
      function logic [LEVEL_BITS-1:0] span_to_q15(logic [11:0] span);
         int unsigned q;
         if (fs == '0)
            return (span != '0) ? LEVEL_ONE : '0;
         q = (int'(span) << 15) / int'(fs);
         return (q > 32768) ? LEVEL_ONE : q[LEVEL_BITS-1:0];
      endfunction

      function void note_tick(logic [TIME_BITS-1:0] now, logic [11:0] sample,
                              logic rdy, logic signed [DIST_BITS-1:0] range_mm);
         tick_result_type r;
         logic [TIME_BITS-1:0] elapsed;
         logic [11:0] span;
         logic pres;
         r = '0;
         if (sample < win_lo) win_lo = sample;
         if (sample > win_hi) win_hi = sample;
         elapsed = now - win_start;
         if (elapsed >= {16'd0, win_len}) begin
            span = (win_hi >= win_lo) ? win_hi - win_lo : 12'd0;
            level = span_to_q15(span);
            win_lo = 12'hFFF;
            win_hi = '0;
            win_start = now;
            r.window_closed = 1'b1;
         end
         // only a positive reading from a fitted sensor is latched
         if (fitted && rdy && range_mm > 0)
            held_dist = range_mm;
         pres = !fitted || (held_dist > 0 && $unsigned(held_dist) < {1'b0, near});
         if (!pres && was_pres)
            absent_from = now;
         was_pres = pres;
         r.noise_level = level;
         r.is_present = pres;
         r.held_distance_mm = held_dist;
         r.absent_ms = pres ? '0 : now - absent_from;
         pending.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         if (errors < MAX_PRINTS)
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(logic [LEVEL_BITS-1:0] noise, logic closed, logic present,
                        logic [DIST_BITS-1:0] held, logic [TIME_BITS-1:0] absent);
         tick_result_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result transaction", {16'd0, noise}, '0);
            return;
         end
         w = pending.pop_front();
         if (noise !== w.noise_level)
            report_mismatch("noise_level", {16'd0, noise}, {16'd0, w.noise_level});
         if (closed !== w.window_closed)
            report_mismatch("window_closed", {31'd0, closed}, {31'd0, w.window_closed});
         if (present !== w.is_present)
            report_mismatch("is_present", {31'd0, present}, {31'd0, w.is_present});
         if (held !== w.held_distance_mm)
            report_mismatch("held_distance_mm", {16'd0, held}, {16'd0, w.held_distance_mm});
         if (absent !== w.absent_ms)
            report_mismatch("absent_ms", absent, w.absent_ms);
      endtask
   endclass

   // ------------------------------------------------------------------
   // signals
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   logic                        req_valid;
   logic                        req_ready;
   logic [TIME_BITS-1:0]        req_now_ms;
   logic [11:0]                 req_mic_sample;
   logic                        req_range_ready;
   logic signed [DIST_BITS-1:0] req_range_mm;

   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [LEVEL_BITS-1:0]       rsp_noise_level;
   logic                        rsp_window_closed;
   logic                        rsp_is_present;
   logic signed [DIST_BITS-1:0] rsp_held_distance_mm;
   logic [TIME_BITS-1:0]        rsp_absent_ms;

   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   level_presence_scoreboard sb = new();

   // stimulus bookkeeping
   logic [TIME_BITS-1:0] tick_time_ms;
   logic [11:0]          last_sample;
   logic [WIN_BITS-1:0]  cur_win;
   logic [NEAR_BITS-1:0] cur_near;
   int                   sender_gap_pct;
   bit                   no_idle;
   int                   stall_cycles;

   mic_level_presence_tracker_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_now_ms           (req_now_ms),
      .req_mic_sample       (req_mic_sample),
      .req_range_ready      (req_range_ready),
      .req_range_mm         (req_range_mm),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_noise_level      (rsp_noise_level),
      .rsp_window_closed    (rsp_window_closed),
      .rsp_is_present       (rsp_is_present),
      .rsp_held_distance_mm (rsp_held_distance_mm),
      .rsp_absent_ms        (rsp_absent_ms),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // 2 ns period, rising edge at odd ns
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // monitor and watchdog: everything sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         // check before note: a result never belongs to a tick taken at the same edge
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_noise_level, rsp_window_closed, rsp_is_present,
                            rsp_held_distance_mm, rsp_absent_ms);
         if (req_valid && req_ready)
            sb.note_tick(req_now_ms, req_mic_sample, req_range_ready, req_range_mm);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // result side backpressure: random stall bursts, none in the last phase
   // ------------------------------------------------------------------
   initial begin : result_backpressure
      int run;
      rsp_ready = 1'b0;
      forever begin
         if (no_idle) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            run = $urandom_range(1, 7);
            repeat (run) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            run = $urandom_range(1, 24);
            repeat (run) begin
               @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // driver tasks
   // ------------------------------------------------------------------

   // one tick transaction, optionally preceded by an idle burst with junk payload
   task automatic send_tick(input logic [TIME_BITS-1:0] now, input logic [11:0] sample,
                            input logic rdy, input logic [DIST_BITS-1:0] mm);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < sender_gap_pct) begin
         gap = $urandom_range(1, 7);
         repeat (gap) begin
            @(negedge clock);
            req_valid       <= 1'b0;
            req_now_ms      <= $urandom;
            req_mic_sample  <= 12'($urandom);
            req_range_ready <= 1'($urandom);
            req_range_mm    <= 16'($urandom);
         end
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_now_ms      <= now;
      req_mic_sample  <= sample;
      req_range_ready <= rdy;
      req_range_mm    <= mm;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait at falling edges until every expected result has come back
   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0)
         @(negedge clock);
   endtask

   // apb write followed by a read back of the same register
   task automatic csr_write_and_verify(input reg_index_type idx,
                                       input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      // read: new setup phase straight after the write
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== value)
         sb.report_mismatch("register read back", readback, value);
   endtask

   // registers change only with the tracker idle
   task automatic apply_settings(input logic [WIN_BITS-1:0] win, input logic [FS_BITS-1:0] fs,
                                 input logic [NEAR_BITS-1:0] near, input logic fitted);
      wait_results_done();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_and_verify(REG_WINDOW_MS, {16'd0, win});
      csr_write_and_verify(REG_FULL_SCALE, {20'd0, fs});
      csr_write_and_verify(REG_NEAR_MM, {17'd0, near});
      csr_write_and_verify(REG_RANGE_FITTED, {31'd0, fitted});
      cur_win  = win;
      cur_near = near;
   endtask

   // mostly a forward-running clock with random content, some jumps, wraps and steps back
   task automatic send_random_tick();
      int unsigned step_max;
      int unsigned pick;
      int unsigned lim;
      logic [11:0] sample;
      logic [DIST_BITS-1:0] mm;
      step_max = (cur_win == '0) ? 3 : int'(cur_win) / 3 + 2;
      pick = $urandom_range(0, 99);
      if (pick < 84)
         tick_time_ms = tick_time_ms + $urandom_range(0, step_max);
      else if (pick < 90)
         tick_time_ms = $urandom;
      else if (pick < 95)
         tick_time_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max);
      else
         tick_time_ms = tick_time_ms - $urandom_range(1, step_max);

      pick = $urandom_range(0, 99);
      if (pick < 15)
         sample = last_sample;
      else if (pick < 20)
         sample = 12'd0;
      else if (pick < 25)
         sample = 12'hFFF;
      else
         sample = 12'($urandom);
      last_sample = sample;

      // readings mostly straddle the near limit so presence keeps flipping
      lim = 2 * int'(cur_near) + 2;
      if (lim > 32767) lim = 32767;
      case ($urandom_range(0, 9))
         0:       mm = '0;
         1:       mm = {1'b1, 15'($urandom)};
         2, 3:    mm = 16'($urandom);
         default: mm = 16'($urandom_range(1, lim));
      endcase
      send_tick(tick_time_ms, sample, 1'($urandom), mm);
   endtask

   task automatic run_random_phase(input int count, input bit drain_midway);
      for (int i = 0; i < count; i++) begin
         // hold the sender off once until the tracker has delivered everything
         if (drain_midway && i == count / 2)
            wait_results_done();
         send_random_tick();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int p;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_now_ms      = '0;
      req_mic_sample  = '0;
      req_range_ready = 1'b0;
      req_range_mm    = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      no_idle         = 1'b0;
      sender_gap_pct  = 0;
      tick_time_ms    = '0;
      last_sample     = '0;
      cur_win         = WINDOW_MS_RST;
      cur_near        = NEAR_MM_RST;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed ticks with reset settings: 1 s window, full scale 1024, near 1000 mm
      send_tick(32'd0,    12'd0,    1'b1, 16'sd500);   // present, window still open
      send_tick(32'd500,  12'd4095, 1'b1, 16'sd0);     // zero reading ignored
      send_tick(32'd1000, 12'd2048, 1'b1, 16'h8000);   // window closes clamped, negative ignored
      send_tick(32'd1500, 12'd2000, 1'b1, 16'sd32767); // far away: absence starts
      send_tick(32'd1600, 12'd1000, 1'b0, 16'sd1);     // reading without ready flag ignored
      send_tick(32'd2100, 12'd100,  1'b1, 16'sd999);   // close and back to present
      send_tick(32'd2200, 12'd2047, 1'b1, 16'sd1000);  // exactly at near limit counts absent
      send_tick(32'd2300, 12'd2047, 1'b1, 16'sd1);
      send_tick(32'hFFFF_FF00, 12'd1024, 1'b0, 16'sd0);
      send_tick(32'h0000_00FF, 12'd1279, 1'b1, 16'hFFFF); // wrap, window stays open
      send_tick(32'h0000_0400, 12'd1024, 1'b0, 16'sd0);   // close across wrap, mid level
      send_tick(32'h0000_07E8, 12'd1024, 1'b0, 16'sd0);   // elapsed equals window exactly

      // zero window, zero full scale, zero near limit
      apply_settings('0, '0, '0, 1'b1);
      send_tick(32'd5, 12'd4095, 1'b1, 16'sd100);
      send_tick(32'd6, 12'd0,    1'b1, 16'sd200);

      // zero full scale with a nonzero span, range sensor absent
      apply_settings(16'd2, '0, 15'd1, 1'b0);
      send_tick(32'd100, 12'd0,    1'b1, 16'sd50);
      send_tick(32'd101, 12'd4095, 1'b1, 16'sd77);
      send_tick(32'd102, 12'd0,    1'b0, 16'sd0);

      // widest settings
      apply_settings(16'hFFFF, 12'hFFF, 15'h7FFF, 1'b1);
      send_tick(32'd65636, 12'd1,    1'b1, 16'sd32766);
      send_tick(32'd65637, 12'd4095, 1'b1, 16'sd32767);
      send_tick(32'd65700, 12'd0,    1'b1, -16'sd5);

      tick_time_ms = 32'd65700;

      // random phases, the last one at reset settings with no idling
      for (p = 0; p < PHASES; p++) begin
         if (p == 0)
            apply_settings('0, '0, '0, 1'b1);
         else if (p == 1)
            apply_settings(16'd1, 12'd1, 15'd1, 1'b0);
         else if (p == 2)
            apply_settings(16'hFFFF, 12'hFFF, 15'h7FFF, 1'b1);
         else if (p == PHASES - 1) begin
            no_idle = 1'b1;
            apply_settings(WINDOW_MS_RST, FULL_SCALE_RST, NEAR_MM_RST, 1'b1);
         end else if (p % 2 == 1)
            apply_settings(16'($urandom), 12'($urandom), 15'($urandom), 1'($urandom));
         else
            apply_settings(16'($urandom_range(2, 300)), 12'($urandom_range(1, 4095)),
                           15'($urandom_range(1, 3000)), $urandom_range(0, 3) != 0);
         case ($urandom_range(0, 2))
            0:       sender_gap_pct = 0;
            1:       sender_gap_pct = 15;
            default: sender_gap_pct = 40;
         endcase
         run_random_phase(ITEMS_PER_PHASE, p == 4);
      end

      wait_results_done();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.pending.size() != 0)
         sb.report_mismatch("results never delivered", sb.pending.size(), '0);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mlpt_pkg.sv
rtl/core/mic_level_presence_tracker_unit.sv
tb/mic_level_presence_tracker_unit_tb.sv
